// ----- rtl/lmss_pkg.sv -----
`default_nettype none

package lmss_pkg;

  localparam int unsigned RowCount  = 8;
  localparam int unsigned RowBits   = 3;
  localparam int unsigned WordBits  = 16;
  localparam int unsigned CntBits   = 4;
  localparam int unsigned CfgIdxBits = 1;

  localparam logic [63:0] PinMapReset        = 64'hFEDC_BA98_7654_3210;
  localparam logic [7:0]  FramesPerStepReset = 8'd1;

  typedef enum logic [1:0] {
    ActPush  = 2'd0,
    ActTick  = 2'd1,
    ActWrite = 2'd2
  } action_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgPinMap        = 1'b0,
    CfgFramesPerStep = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] row_data;
    logic [2:0] row_index;
  } in_item_t;

  typedef struct packed {
    logic serial_bit;
    logic store_after;
    logic step_done;
  } out_item_t;

  // one scanned row, already remapped to physical pin order
  typedef struct packed {
    logic [WordBits-1:0] word;
    logic                done;
  } scan_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

// ----- rtl/lmss_queue.sv -----
`default_nettype none

module lmss_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire lmss_pkg::scan_word_t   push_data_i,
  input  wire logic                   pop_i,
  output lmss_pkg::scan_word_t        pop_data_o,
  output lmss_pkg::queue_status_t     status_o
);
  import lmss_pkg::*;

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(Depth - 1);
  localparam logic [CntW-1:0]    FullCnt = CntW'(Depth);

  scan_word_t         mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               do_push, do_pop;

  assign status_o.full  = (count_q == FullCnt);
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && status_o.full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && status_o.empty))
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ----- rtl/lmss_front.sv -----
`default_nettype none

module lmss_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire lmss_pkg::in_item_t           in_item_i,
  output logic                              in_stall_o,
  input  wire logic                         cfg_valid_i,
  input  wire logic [lmss_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [63:0]                  cfg_data_i,
  output logic                              cfg_ready_o,
  output logic                              push_o,
  output lmss_pkg::scan_word_t              push_data_o,
  input  wire lmss_pkg::queue_status_t      queue_status_i
);
  import lmss_pkg::*;

  logic [7:0]          rows_q [RowCount];
  logic [RowBits-1:0]  scan_row_q;
  logic [7:0]          frame_count_q;
  logic [63:0]         pin_map_q;
  logic [7:0]          frames_per_step_q;

  logic                accept;
  logic                is_push, is_tick, is_write;
  logic [7:0]          row_byte;
  logic [7:0]          col_sel;
  logic [WordBits-1:0] logical_word;
  logic [WordBits-1:0] phys_word;
  logic [7:0]          target;
  logic [8:0]          next_count;
  logic                last_row;
  logic                frame_done;

  assign in_stall_o  = queue_status_i.full;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    is_push  = 1'b0;
    is_tick  = 1'b0;
    is_write = 1'b0;
    unique case (in_item_i.action)
      ActPush:  is_push  = 1'b1;
      ActTick:  is_tick  = 1'b1;
      ActWrite: is_write = 1'b1;
      default:  ;
    endcase
  end

  // scanned row word: pixels low, active-low column select high
  assign row_byte     = rows_q[scan_row_q];
  assign col_sel      = ~(8'd1 << scan_row_q);
  assign logical_word = {col_sel, row_byte};

  // per output pin, the highest logical bit mapped to it wins; unmapped pins read 0
  always_comb begin
    phys_word = '0;
    for (int p = 0; p < WordBits; p++) begin
      for (int k = 0; k < WordBits; k++) begin
        if (pin_map_q[4*k +: 4] == CntBits'(p)) begin
          phys_word[p] = logical_word[k];
        end
      end
    end
  end

  assign target     = (frames_per_step_q == '0) ? 8'd1 : frames_per_step_q;
  assign last_row   = (scan_row_q == RowBits'(RowCount - 1));
  assign next_count = {1'b0, frame_count_q} + 9'd1;
  assign frame_done = last_row && (next_count >= {1'b0, target});

  assign push_o           = accept && is_tick;
  assign push_data_o.word = phys_word;
  assign push_data_o.done = frame_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RowCount; i++) begin
        rows_q[i] <= '0;
      end
      scan_row_q        <= '0;
      frame_count_q     <= '0;
      pin_map_q         <= PinMapReset;
      frames_per_step_q <= FramesPerStepReset;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgPinMap:        pin_map_q         <= cfg_data_i;
          CfgFramesPerStep: frames_per_step_q <= cfg_data_i[7:0];
          default:          ;
        endcase
      end
      if (accept && is_push) begin
        for (int i = 0; i < RowCount - 1; i++) begin
          rows_q[i] <= rows_q[i+1];
        end
        rows_q[RowCount-1] <= in_item_i.row_data;
      end
      if (accept && is_write) begin
        rows_q[in_item_i.row_index] <= in_item_i.row_data;
      end
      if (accept && is_tick) begin
        scan_row_q <= scan_row_q + RowBits'(1);
        if (last_row) begin
          frame_count_q <= frame_done ? 8'd0 : next_count[7:0];
        end
      end
    end
  end

  a_scan_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> scan_row_q == $past(scan_row_q) + RowBits'(1))
    else $error("scan row did not advance on tick");

  a_done_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && push_data_o.done) |-> last_row)
    else $error("step done outside last row");

  a_count_below_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && last_row && !frame_done) |=> frame_count_q != '0)
    else $error("frame count lost on frame end");

endmodule

`default_nettype wire

// ----- rtl/lmss_shifter.sv -----
`default_nettype none

module lmss_shifter (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  output logic                          pop_o,
  input  wire lmss_pkg::scan_word_t     pop_data_i,
  input  wire lmss_pkg::queue_status_t  queue_status_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output lmss_pkg::out_item_t           out_item_o
);
  import lmss_pkg::*;

  localparam logic [CntBits-1:0] LastBit = CntBits'(WordBits - 1);

  logic [WordBits-1:0] shift_q, shift_d;
  logic [CntBits-1:0]  bit_cnt_q, bit_cnt_d;
  logic                done_q, done_d;
  logic                valid_q, valid_d;
  logic                taken;
  logic                last_bit;

  assign taken    = valid_q && !out_stall_i;
  assign last_bit = (bit_cnt_q == LastBit);

  // load a new word when idle or when the last bit of the current one leaves
  assign pop_o = !queue_status_i.empty && (!valid_q || (taken && last_bit));

  always_comb begin
    shift_d   = shift_q;
    bit_cnt_d = bit_cnt_q;
    done_d    = done_q;
    valid_d   = valid_q;
    if (pop_o) begin
      shift_d   = pop_data_i.word;
      done_d    = pop_data_i.done;
      bit_cnt_d = '0;
      valid_d   = 1'b1;
    end else if (taken) begin
      if (last_bit) begin
        valid_d = 1'b0;
      end else begin
        shift_d   = {shift_q[WordBits-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      bit_cnt_q <= '0;
    end else begin
      valid_q   <= valid_d;
      bit_cnt_q <= bit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    done_q  <= done_d;
  end

  assign out_valid_o            = valid_q;
  assign out_item_o.serial_bit  = shift_q[WordBits-1];
  assign out_item_o.store_after = last_bit;
  assign out_item_o.step_done   = last_bit && done_q;

  a_word_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (taken && !last_bit) |=> valid_q)
    else $error("word cut short");

  a_done_on_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_item_o.step_done) |-> out_item_o.store_after)
    else $error("step done without store pulse");

  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("output transaction changed while stalled");

endmodule

`default_nettype wire

// ----- rtl/led_matrix_scroll_scan_shift_out.sv -----
`default_nettype none

// LED matrix scan driver for two chained 8-bit shift registers. Push and row-write
// transactions only update the 8-row window. A refresh tick remaps the current row
// through the pin map and queues it (up to QueueDepth ticks); each queued row is then
// sent as 16 output transactions, MSB first, one per cycle while out_stall_i is low;
// store_after marks the sixteenth. Sustained rate is set by the one-bit-per-cycle
// serializer; input stall rises only when the tick queue is full. Configuration
// writes are always ready and take effect at once; write them only while the block
// is idle.
module led_matrix_scroll_scan_shift_out #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire lmss_pkg::in_item_t              in_item_i,
  output logic                                 in_stall_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output lmss_pkg::out_item_t                  out_item_o,
  input  wire logic                            cfg_valid_i,
  input  wire logic [lmss_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [63:0]                     cfg_data_i,
  output logic                                 cfg_ready_o
);
  import lmss_pkg::*;

  logic          push;
  scan_word_t    push_data;
  logic          pop;
  scan_word_t    pop_data;
  queue_status_t queue_status;

  lmss_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_item_i      (in_item_i),
    .in_stall_o     (in_stall_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_ready_o    (cfg_ready_o),
    .push_o         (push),
    .push_data_o    (push_data),
    .queue_status_i (queue_status)
  );

  lmss_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (queue_status)
  );

  lmss_shifter u_shifter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_o          (pop),
    .pop_data_i     (pop_data),
    .queue_status_i (queue_status),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_item_o     (out_item_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb_led_matrix_scroll_scan_shift_out.sv -----
`default_nettype none

module tb_led_matrix_scroll_scan_shift_out;
  timeunit 1ns;
  timeprecision 1ps;

  import lmss_pkg::*;

  localparam logic [1:0]  ActUnused   = 2'd3;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned PhaseItems  = 48;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_item = '0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  cfg_idx_e    cfg_index = CfgPinMap;
  logic [63:0] cfg_data = '0;
  logic        cfg_ready;

  // predicted block state and configuration
  logic [7:0]  win_rows [RowCount];
  logic [2:0]  scan_row_m;
  logic [7:0]  frames_done;
  logic [63:0] pin_map_m;
  logic [7:0]  frames_target;
  out_item_t   pending_bits [$];

  out_item_t   bit_exp;
  int unsigned mismatches = 0;
  logic        calm = 1'b0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  led_matrix_scroll_scan_shift_out u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_item_i   (in_item),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .cfg_ready_o (cfg_ready)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] remap_pins(input logic [15:0] logical);
    logic [15:0] phys;
    logic [3:0]  pos;
    phys = '0;
    // later entries overwrite earlier ones on the same output position
    for (int k = 0; k < WordBits; k++) begin
      pos = pin_map_m[4*k +: 4];
      phys[pos] = logical[k];
    end
    return phys;
  endfunction

  task automatic predict_serial_bits(input in_item_t item);
    logic [7:0]  col_sel;
    logic [15:0] phys;
    logic        done;
    logic [8:0]  next_cnt;
    logic [8:0]  target;
    out_item_t   bit_next;
    case (item.action)
      ActPush: begin
        for (int i = 0; i < RowCount - 1; i++) win_rows[i] = win_rows[i+1];
        win_rows[RowCount-1] = item.row_data;
      end
      ActWrite: begin
        win_rows[item.row_index] = item.row_data;
      end
      ActTick: begin
        col_sel = 8'hFF;
        col_sel[scan_row_m] = 1'b0;
        phys = remap_pins({col_sel, win_rows[scan_row_m]});
        done = 1'b0;
        target = (frames_target == 8'd0) ? 9'd1 : {1'b0, frames_target};
        if (scan_row_m == 3'(RowCount - 1)) begin
          next_cnt = {1'b0, frames_done} + 9'd1;
          if (next_cnt >= target) begin
            done = 1'b1;
            frames_done = 8'd0;
          end else begin
            frames_done = next_cnt[7:0];
          end
        end
        scan_row_m = scan_row_m + 3'd1;
        for (int i = 0; i < WordBits; i++) begin
          bit_next.serial_bit  = phys[WordBits-1-i];
          bit_next.store_after = (i == WordBits - 1);
          bit_next.step_done   = (i == WordBits - 1) && done;
          pending_bits.push_back(bit_next);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input in_item_t item);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_item   <= item;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (in_stall);
    predict_serial_bits(item);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [63:0] data);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CfgPinMap:        pin_map_m = data;
      CfgFramesPerStep: frames_target = data[7:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic in_item_t rand_item();
    in_item_t    item;
    logic [31:0] r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40)      item.action = ActTick;
    else if (pick < 68) item.action = ActPush;
    else if (pick < 95) item.action = ActWrite;
    else                item.action = ActUnused;
    r = $urandom;
    pick = $urandom_range(9);
    item.row_data  = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : r[7:0];
    item.row_index = r[10:8];
    return item;
  endfunction

  task automatic test_row_ops();
    in_item_t tick;
    send_item(in_item_t'{ActPush, 8'hFF, 3'd7});
    send_item(in_item_t'{ActPush, 8'h00, 3'd0});
    send_item(in_item_t'{ActPush, 8'hA5, 3'd2});
    send_item(in_item_t'{ActWrite, 8'hFF, 3'd0});
    send_item(in_item_t'{ActWrite, 8'h3C, 3'd7});
    // unused action code must leave the window alone
    send_item(in_item_t'{ActUnused, 8'hFF, 3'd7});
    // one full frame with the reset frame count raises step done
    for (int i = 0; i < RowCount; i++) begin
      tick = in_item_t'{ActTick, (i[0] ? 8'hFF : 8'h00), (i[0] ? 3'd7 : 3'd0)};
      send_item(tick);
    end
  endtask

  task automatic test_pin_map_collisions();
    drain();
    // every entry on position zero: logical bit 15 wins, the rest read 0
    write_cfg(CfgPinMap, 64'h0);
    send_item(in_item_t'{ActTick, 8'h00, 3'd0});
    drain();
    write_cfg(CfgPinMap, '1);
    send_item(in_item_t'{ActTick, 8'hFF, 3'd7});
    drain();
    write_cfg(CfgPinMap, 64'h0123_4567_89AB_CDEF);
    send_item(in_item_t'{ActTick, 8'h00, 3'd0});
  endtask

  task automatic test_backpressure();
    drain();
    hold_toggle <= ~hold_toggle;
    calm = 1'b1;
    // ticks keep coming while the receiver holds off, so input stall must rise
    for (int i = 0; i < 12; i++) send_item(in_item_t'{ActTick, 8'h5A, 3'd3});
    calm = 1'b0;
    drain();
  endtask

  task automatic test_random_phases();
    logic [63:0] map;
    logic [7:0]  fps;
    logic [31:0] r;
    in_item_t    item;
    int unsigned sent;
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin
          for (int k = 0; k < WordBits; k++) begin
            r = $urandom_range(3);
            map[4*k +: 4] = r[3:0];
          end
        end
        3:       map = PinMapReset;
        default: map = {$urandom, $urandom};
      endcase
      case (ph)
        0:       fps = 8'd2;
        1:       fps = 8'd255;
        2:       fps = 8'd1;
        3:       fps = 8'd0;
        4:       fps = 8'd3;
        6:       fps = 8'd255;
        default: begin
          r = $urandom_range(1, 6);
          fps = r[7:0];
        end
      endcase
      write_cfg(CfgPinMap, map);
      write_cfg(CfgFramesPerStep, {56'd0, fps});
      calm = (ph == 4);
      sent = 0;
      while (sent < PhaseItems) begin
        item = rand_item();
        send_item(item);
        if (item.action != ActUnused) sent++;
        if (ph == 2 && sent == PhaseItems / 2) drain();
      end
      calm = 1'b0;
    end
  endtask

  // receiver: random stall, or a long counted hold-off on request
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 9);
    end
  end

  // compare every accepted output transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bits.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected output transaction: serial %b store %b done %b",
                   out_item.serial_bit, out_item.store_after, out_item.step_done);
      end else begin
        bit_exp = pending_bits.pop_front();
        if (out_item.serial_bit !== bit_exp.serial_bit ||
            out_item.store_after !== bit_exp.store_after ||
            out_item.step_done !== bit_exp.step_done) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("mismatch: expected serial %b store %b done %b, got %b %b %b",
                     bit_exp.serial_bit, bit_exp.store_after, bit_exp.step_done,
                     out_item.serial_bit, out_item.store_after, out_item.step_done);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < RowCount; i++) win_rows[i] = 8'h00;
    scan_row_m    = '0;
    frames_done   = '0;
    pin_map_m     = PinMapReset;
    frames_target = FramesPerStepReset;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_row_ops();
    test_pin_map_collisions();
    test_random_phases();
    test_backpressure();
    drain();
    if (mismatches == 0 && pending_bits.size() == 0) begin
      $display("tb_led_matrix_scroll_scan_shift_out OK");
    end else begin
      $display("tb_led_matrix_scroll_scan_shift_out NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_led_matrix_scroll_scan_shift_out NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/lmss_pkg.sv
rtl/lmss_queue.sv
rtl/lmss_front.sv
rtl/lmss_shifter.sv
rtl/led_matrix_scroll_scan_shift_out.sv
tb/tb_led_matrix_scroll_scan_shift_out.sv
